// ===== rtl/scle_pkg.sv =====
// Shared types, constants and echo text lookup for the serial console line editor.
// Used by scle_ctrl, scle_dp and serial_console_line_editor_core; depends on nothing.
package scle_pkg;

	localparam int LINE_DEPTH = 64;
	localparam int IDX_W      = $clog2(LINE_DEPTH);
	localparam int CNT_W      = (IDX_W > 4) ? IDX_W : 4;

	localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(LINE_DEPTH - 1);

	localparam logic [7:0] CH_BS       = 8'd8;
	localparam logic [7:0] CH_LF       = 8'd10;
	localparam logic [7:0] CH_CR       = 8'd13;
	localparam logic [7:0] CH_SP       = 8'd32;
	localparam logic [7:0] CH_DEL      = 8'd127;
	localparam logic [7:0] CH_PRINT_LO = 8'd32;
	localparam logic [7:0] CH_PRINT_HI = 8'd126;

	localparam logic [3:0] TEXT_CRLF_BASE   = 4'd0;
	localparam logic [3:0] TEXT_PROMPT_BASE = 4'd2;
	localparam logic [3:0] ECHO_N_NONE      = 4'd0;
	localparam logic [3:0] ECHO_N_CHAR      = 4'd1;
	localparam logic [3:0] ECHO_N_CRLF      = 4'd2;
	localparam logic [3:0] ECHO_N_ERASE     = 4'd3;
	localparam logic [3:0] ECHO_N_PROMPT    = 4'd7;
	localparam logic [3:0] ECHO_N_FULL      = 4'd9;

	typedef enum logic [1:0] {
		ECHO_CHAR,
		ECHO_ERASE,
		ECHO_TEXT
	} echo_sel_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
		logic       enable_value;
	} in_req_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_char;
		logic       cmd_valid;
		logic [7:0] cmd_char;
		logic [5:0] cmd_length;
		logic       last;
	} out_req_t;

	typedef struct packed {
		logic take;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic has_results;
		logic final_idx;
		logic out_free;
	} ctl_sts_t;

	// CR LF followed by the prompt "debug> "
	function automatic logic [7:0] text_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = CH_CR;
			4'd1:    ch = CH_LF;
			4'd2:    ch = 8'h64;
			4'd3:    ch = 8'h65;
			4'd4:    ch = 8'h62;
			4'd5:    ch = 8'h75;
			4'd6:    ch = 8'h67;
			4'd7:    ch = 8'h3e;
			4'd8:    ch = CH_SP;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] echo_char_f(input echo_sel_t sel, input logic [3:0] idx,
			input logic [7:0] rx_byte);
		logic [7:0] ch;
		case (sel)
			ECHO_CHAR:  ch = rx_byte;
			ECHO_ERASE: ch = (idx == 4'd1) ? CH_SP : CH_BS;
			ECHO_TEXT:  ch = text_char(idx);
			default:    ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/scle_ctrl.sv =====
// Controller state machine of the line editor: accepts requests and sequences result loads.
// Depends on scle_pkg; drives the datapath scle_dp through ctl_cmd_t.
module scle_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  scle_pkg::ctl_sts_t sts,
	output scle_pkg::ctl_cmd_t cmd
);

	scle_pkg::state_t state_q;
	scle_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			scle_pkg::ST_IDLE: begin
				if (item_valid && sts.has_results) begin
					state_d = scle_pkg::ST_EMIT;
				end
			end
			scle_pkg::ST_EMIT: begin
				if (sts.out_free && sts.final_idx) begin
					state_d = scle_pkg::ST_IDLE;
				end
			end
			default: state_d = scle_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		cmd.take   = 1'b0;
		cmd.load   = 1'b0;
		case (state_q)
			scle_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				cmd.take   = item_valid;
			end
			scle_pkg::ST_EMIT: begin
				cmd.load = sts.out_free;
			end
			default: item_stall = 1'b1;
		endcase
	end

endmodule

// ===== rtl/scle_dp.sv =====
// Datapath of the line editor: byte decode, line memory, editor state and result register.
// Depends on scle_pkg; commanded by scle_ctrl.
module scle_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  scle_pkg::in_req_t  item,
	input  scle_pkg::ctl_cmd_t cmd,
	output scle_pkg::ctl_sts_t sts,
	output logic               result_valid,
	input  logic               result_stall,
	output scle_pkg::out_req_t result
);

	localparam int IDX_W = scle_pkg::IDX_W;
	localparam int CNT_W = scle_pkg::CNT_W;

	logic [7:0]          line_mem [scle_pkg::LINE_DEPTH];
	logic [7:0]          rd_q;
	logic                enabled_q;
	logic [IDX_W-1:0]    len_q;
	logic [7:0]          prev_q;
	logic [CNT_W-1:0]    k_q;
	logic [CNT_W-1:0]    total_q;
	scle_pkg::echo_sel_t echo_sel_q;
	logic [3:0]          echo_base_q;
	logic [3:0]          echo_n_q;
	logic [IDX_W-1:0]    cmd_n_q;
	logic [7:0]          byte_q;
	scle_pkg::out_req_t  res_q;
	logic                res_valid_q;

	logic                nxt_enabled;
	logic [IDX_W-1:0]    nxt_len;
	logic [7:0]          nxt_prev;
	logic                wr_en;
	logic                crlf;
	scle_pkg::echo_sel_t d_sel;
	logic [3:0]          d_base;
	logic [3:0]          d_n;
	logic [IDX_W-1:0]    d_cmd_n;
	logic [CNT_W-1:0]    d_echo_w;
	logic [CNT_W-1:0]    d_cmd_w;
	logic [CNT_W-1:0]    k_next;
	logic [IDX_W-1:0]    rd_addr;
	logic                ev;
	logic                cv;
	scle_pkg::out_req_t  res_d;

	always_comb begin
		nxt_enabled = enabled_q;
		nxt_len     = len_q;
		nxt_prev    = prev_q;
		wr_en       = 1'b0;
		d_sel       = scle_pkg::ECHO_TEXT;
		d_base      = scle_pkg::TEXT_CRLF_BASE;
		d_n         = scle_pkg::ECHO_N_NONE;
		d_cmd_n     = '0;
		crlf        = (item.rx_byte == scle_pkg::CH_CR) || (prev_q != scle_pkg::CH_CR);
		if (item.action) begin
			nxt_enabled = item.enable_value;
		end else begin
			nxt_prev = item.rx_byte;
			if (!enabled_q) begin
				if (item.rx_byte == scle_pkg::CH_CR || item.rx_byte == scle_pkg::CH_LF) begin
					nxt_enabled = 1'b1;
					nxt_len     = '0;
					d_base      = scle_pkg::TEXT_PROMPT_BASE;
					d_n         = scle_pkg::ECHO_N_PROMPT;
				end
			end else if (item.rx_byte inside {[scle_pkg::CH_PRINT_LO:scle_pkg::CH_PRINT_HI]}) begin
				if (len_q != scle_pkg::LEN_MAX) begin
					wr_en   = 1'b1;
					nxt_len = len_q + 1'b1;
					d_sel   = scle_pkg::ECHO_CHAR;
					d_n     = scle_pkg::ECHO_N_CHAR;
				end
			end else if (item.rx_byte == scle_pkg::CH_BS || item.rx_byte == scle_pkg::CH_DEL) begin
				if (len_q != '0) begin
					nxt_len = len_q - 1'b1;
					d_sel   = scle_pkg::ECHO_ERASE;
					d_n     = scle_pkg::ECHO_N_ERASE;
				end
			end else if (item.rx_byte == scle_pkg::CH_CR || item.rx_byte == scle_pkg::CH_LF) begin
				if (len_q != '0) begin
					d_cmd_n = len_q;
					nxt_len = '0;
					d_n     = crlf ? scle_pkg::ECHO_N_CRLF : scle_pkg::ECHO_N_NONE;
				end else begin
					d_base = crlf ? scle_pkg::TEXT_CRLF_BASE : scle_pkg::TEXT_PROMPT_BASE;
					d_n    = crlf ? scle_pkg::ECHO_N_FULL : scle_pkg::ECHO_N_PROMPT;
				end
			end
		end
	end

	assign d_echo_w        = CNT_W'(d_n);
	assign d_cmd_w         = CNT_W'(d_cmd_n);
	assign sts.has_results = (d_n != scle_pkg::ECHO_N_NONE) || (d_cmd_n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			len_q     <= '0;
			prev_q    <= 8'h00;
		end else if (cmd.take) begin
			enabled_q <= nxt_enabled;
			len_q     <= nxt_len;
			prev_q    <= nxt_prev;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			echo_sel_q  <= d_sel;
			echo_base_q <= d_base;
			echo_n_q    <= d_n;
			cmd_n_q     <= d_cmd_n;
			byte_q      <= item.rx_byte;
			total_q     <= (d_echo_w > d_cmd_w) ? d_echo_w : d_cmd_w;
		end
	end

	assign k_next  = k_q + 1'b1;
	assign rd_addr = cmd.take ? '0 : (cmd.load ? k_next[IDX_W-1:0] : k_q[IDX_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.take) begin
			k_q <= '0;
		end else if (cmd.load) begin
			k_q <= k_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && wr_en) begin
			line_mem[len_q] <= item.rx_byte;
		end
		rd_q <= line_mem[rd_addr];
	end

	assign sts.final_idx = ({1'b0, k_q} + 1'b1) == {1'b0, total_q};
	assign sts.out_free  = !res_valid_q || !result_stall;

	assign ev = CNT_W'(echo_n_q) > k_q;
	assign cv = CNT_W'(cmd_n_q) > k_q;

	always_comb begin
		res_d.echo_valid = ev;
		res_d.echo_char  = ev ? scle_pkg::echo_char_f(echo_sel_q, echo_base_q + k_q[3:0], byte_q)
				: 8'h00;
		res_d.cmd_valid  = cv;
		res_d.cmd_char   = cv ? rd_q : 8'h00;
		res_d.cmd_length = cv ? 6'(cmd_n_q) : 6'd0;
		res_d.last       = sts.final_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== rtl/serial_console_line_editor_core.sv =====
// Top level of the serial console line editor: joins controller scle_ctrl and datapath scle_dp.
// Depends on scle_pkg.
//
// Usage: the item channel (item_valid, item_stall, item) carries one request per received
// UART byte or software enable write. The result channel (result_valid, result_stall,
// result) returns echo bytes and command-line bytes, one result per cycle while result_stall is low, last flagged.
// A request that causes no result (ignored byte, enable write, dropped byte) is taken at
// once from ST_IDLE and the next request may follow in the next cycle.
// A request that causes N results is taken in ST_IDLE; in ST_EMIT its results then load into
// the output register one per cycle while result_stall does not hold them, paced by the
// single read port of the 64-entry line memory. N is at most 63 for a line end and at most
// 9 for echo alone.
// item_stall is high while results are being sequenced. When the receiver holds
// result_stall, the result register keeps its request and sequencing pauses.
// Reset (arst_n low) disables the editor, empties the line and drops any pending result;
// the line memory keeps its contents and needs no clearing pass.
module serial_console_line_editor_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  scle_pkg::in_req_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output scle_pkg::out_req_t result
);

	scle_pkg::ctl_cmd_t cmd;
	scle_pkg::ctl_sts_t sts;

	scle_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	scle_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_final_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && sts.final_idx) |=> (result_valid && result.last))
		else $error("final load did not present a last result");

	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.echo_valid || result.cmd_valid))
		else $error("result carries neither echo nor command byte");

	a_cmd_length: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.cmd_valid) |-> (result.cmd_length != 6'd0))
		else $error("command byte with zero line length");

endmodule
